### hdl/xsti_pkg.sv
// Shared types, widths and constant tables of the cross-section interpolator.
// Used by xsti_sqrt, xsti_div and cross_section_table_interpolator_top; no dependencies.
package xsti_pkg;

    // Field widths.
    localparam int S_W   = 32;             // squared energy, Q8.24 GeV^2
    localparam int E_W   = 20;             // root and table energies, Q4.16 GeV
    localparam int Y_W   = 16;             // cross section, Q0.16 mb
    localparam int RAD_W = 2 * E_W;        // radicand after the Q8.24 -> Q8.32 shift
    localparam int PAD_W = RAD_W - S_W;

    // Table geometry.
    localparam int NUM_ROWS = 28;
    localparam int ROW_W    = $clog2(NUM_ROWS);
    localparam int IDX_W    = $clog2(NUM_ROWS + 1);

    // Widest gap between neighboring table energies fits in DEN_W bits.
    localparam int DEN_W  = 11;
    localparam int PROD_W = Y_W + DEN_W;
    localparam int N_W    = PROD_W + 1;    // 2*num + den
    localparam int D_W    = DEN_W + 1;     // 2*den

    // Square root: two radicand bits per step, four steps per stage.
    localparam int SQ_STEPS     = 4;
    localparam int SQ_STAGES    = E_W / SQ_STEPS;
    localparam int SQ_REM_W     = E_W + 1;

    // Divider: one quotient bit per step, four steps per stage.
    localparam int DV_STEPS  = 4;
    localparam int DV_STAGES = Y_W / DV_STEPS;

    typedef enum logic [1:0] {
        REGION_BELOW  = 2'd0,
        REGION_INTERP = 2'd1,
        REGION_ABOVE  = 2'd2
    } t_region;

    // Side information that rides along the divider pipeline.
    typedef struct packed {
        t_region        region;
        logic           bypass;
        logic [Y_W-1:0] y_bypass;
    } t_side;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [E_W-1:0]      root;
    } t_sq;

    // Table energies: proton mass plus offset, Q4.16 GeV, rounded to nearest.
    localparam logic [E_W-1:0] ROM_E [NUM_ROWS] = '{
        20'd73615, 20'd74925, 20'd76105, 20'd77350, 20'd78530, 20'd79775,
        20'd80496, 20'd81020, 20'd82134, 20'd82331, 20'd83576, 20'd83773,
        20'd84887, 20'd85411, 20'd86198, 20'd87050, 20'd87508, 20'd88688,
        20'd88885, 20'd90195, 20'd90326, 20'd91571, 20'd91965, 20'd93013,
        20'd93603, 20'd94390, 20'd95242, 20'd95831
    };

    // Table cross sections, Q0.16 mb, rounded to nearest.
    localparam logic [Y_W-1:0] ROM_Y [NUM_ROWS] = '{
        16'd0,     16'd7792,  16'd11023, 16'd13264, 16'd21194, 16'd25369,
        16'd31916, 16'd33043, 16'd34531, 16'd34904, 16'd35540, 16'd31313,
        16'd31510, 16'd26647, 16'd26935, 16'd21896, 16'd20441, 16'd16017,
        16'd16358, 16'd13822, 16'd14713, 16'd11416, 16'd13140, 16'd12373,
        16'd11685, 16'd11561, 16'd11593, 16'd10951
    };

    // One step of the digit-by-digit square root.
    function automatic t_sq sqrt_step(input t_sq cur, input logic [1:0] pair);
        logic [SQ_REM_W+1:0] rem_sh;
        logic [SQ_REM_W+1:0] trial;
        t_sq                 res;
        rem_sh = {cur.rem, pair};
        trial  = (SQ_REM_W + 2)'({cur.root, 2'b01});
        if (rem_sh >= trial) begin
            res.rem  = SQ_REM_W'(rem_sh - trial);
            res.root = {cur.root[E_W-2:0], 1'b1};
        end else begin
            res.rem  = SQ_REM_W'(rem_sh);
            res.root = {cur.root[E_W-2:0], 1'b0};
        end
        return res;
    endfunction

    // One step of restoring division: result is {new remainder, quotient bit}.
    function automatic logic [D_W:0] div_step(input logic [D_W-1:0] rem,
                                              input logic           nbit,
                                              input logic [D_W-1:0] dvs);
        logic [D_W:0] rem_sh;
        logic [D_W:0] res;
        rem_sh = {rem, nbit};
        if (rem_sh >= {1'b0, dvs}) begin
            res = {D_W'(rem_sh - {1'b0, dvs}), 1'b1};
        end else begin
            res = {rem_sh[D_W-1:0], 1'b0};
        end
        return res;
    endfunction

endpackage

### hdl/xsti_sqrt.sv
// Pipelined floor square root of the shifted squared energy, four result bits per stage.
// Depends on xsti_pkg.
module xsti_sqrt
    import xsti_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [S_W-1:0] i_radicand,
    output logic           o_valid,
    output logic [E_W-1:0] o_root
);

    logic                 r_vld  [SQ_STAGES];
    t_sq                  r_sq   [SQ_STAGES];
    logic [RAD_W-1:0]     r_rad  [SQ_STAGES];
    t_sq                  n_sq   [SQ_STAGES];
    logic [RAD_W-1:0]     n_rad  [SQ_STAGES];

    always_comb begin
        t_sq              cur;
        logic [RAD_W-1:0] rad;
        for (int st = 0; st < SQ_STAGES; st++) begin
            if (st == 0) begin
                cur = '0;
                rad = {i_radicand, PAD_W'(0)};
            end else begin
                cur = r_sq[st-1];
                rad = r_rad[st-1];
            end
            for (int k = 0; k < SQ_STEPS; k++) begin
                cur = sqrt_step(cur, rad[RAD_W-1 -: 2]);
                rad = {rad[RAD_W-3:0], 2'b00};
            end
            n_sq[st]  = cur;
            n_rad[st] = rad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int st = 0; st < SQ_STAGES; st++) r_vld[st] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int st = 1; st < SQ_STAGES; st++) r_vld[st] <= r_vld[st-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int st = 0; st < SQ_STAGES; st++) begin
                r_sq[st]  <= n_sq[st];
                r_rad[st] <= n_rad[st];
            end
        end
    end

    assign o_valid = r_vld[SQ_STAGES-1];
    assign o_root  = r_sq[SQ_STAGES-1].root;

endmodule

### hdl/xsti_div.sv
// Pipelined restoring divider for the rounded interpolation quotient, four bits per stage.
// Depends on xsti_pkg.
module xsti_div
    import xsti_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [N_W-1:0] i_dividend,
    input  logic [D_W-1:0] i_divisor,
    input  t_side          i_side,
    output logic           o_valid,
    output logic [Y_W-1:0] o_quotient,
    output t_side          o_side
);

    logic           r_vld  [DV_STAGES];
    logic [D_W-1:0] r_rem  [DV_STAGES];
    logic [Y_W-1:0] r_low  [DV_STAGES];
    logic [Y_W-1:0] r_quo  [DV_STAGES];
    logic [D_W-1:0] r_dvs  [DV_STAGES];
    t_side          r_side [DV_STAGES];
    logic [D_W-1:0] n_rem  [DV_STAGES];
    logic [Y_W-1:0] n_low  [DV_STAGES];
    logic [Y_W-1:0] n_quo  [DV_STAGES];

    // The quotient never exceeds Y_W bits, so the high part of the dividend
    // is already below the divisor and serves as the starting remainder.
    always_comb begin
        logic [D_W-1:0] rem;
        logic [Y_W-1:0] low;
        logic [Y_W-1:0] quo;
        logic [D_W-1:0] dvs;
        logic [D_W:0]   stp;
        for (int st = 0; st < DV_STAGES; st++) begin
            if (st == 0) begin
                rem = i_dividend[N_W-1 -: D_W];
                low = i_dividend[Y_W-1:0];
                quo = '0;
                dvs = i_divisor;
            end else begin
                rem = r_rem[st-1];
                low = r_low[st-1];
                quo = r_quo[st-1];
                dvs = r_dvs[st-1];
            end
            for (int k = 0; k < DV_STEPS; k++) begin
                stp = div_step(rem, low[Y_W-1], dvs);
                rem = stp[D_W:1];
                quo = {quo[Y_W-2:0], stp[0]};
                low = {low[Y_W-2:0], 1'b0};
            end
            n_rem[st] = rem;
            n_low[st] = low;
            n_quo[st] = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int st = 0; st < DV_STAGES; st++) r_vld[st] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int st = 1; st < DV_STAGES; st++) r_vld[st] <= r_vld[st-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dvs[0]  <= i_divisor;
            r_side[0] <= i_side;
            for (int st = 1; st < DV_STAGES; st++) begin
                r_dvs[st]  <= r_dvs[st-1];
                r_side[st] <= r_side[st-1];
            end
            for (int st = 0; st < DV_STAGES; st++) begin
                r_rem[st] <= n_rem[st];
                r_low[st] <= n_low[st];
                r_quo[st] <= n_quo[st];
            end
        end
    end

    assign o_valid    = r_vld[DV_STAGES-1];
    assign o_quotient = r_quo[DV_STAGES-1];
    assign o_side     = r_side[DV_STAGES-1];

endmodule

### hdl/cross_section_table_interpolator_top.sv
// Top level of the cross-section table interpolator.
// Depends on xsti_pkg, xsti_sqrt and xsti_div.
//
// The block turns a squared center-of-mass energy s (unsigned Q8.24 GeV^2) into a
// cross section (unsigned Q0.16 mb) by piecewise linear lookup in a fixed table of
// 28 (energy, cross section) rows. It first takes floor(sqrt(s)) to 16 fractional
// bits, finds the first row whose energy exceeds that root, and interpolates
// between that row and the one before it with round-to-nearest (half up). Below
// the first row the result is zero with region 0; at or beyond the last row the
// last cross section is held with region 2; otherwise region is 1. The block is
// a fully pipelined datapath with no state between transactions: it accepts one
// transaction every cycle while not stalled. Fourteen register stages lie between
// input and output: the square root (five stages of four result bits each), the
// row search, the segment operands, the two interpolation products, the rounded
// dividend, the division (four stages of four quotient bits each), and the output
// register. A result is taken from the output register at an edge where the
// output is not stalled. The whole pipeline advances together; a stall on the
// output freezes every stage while a finished result waits, and o_stall is
// raised only then.
module cross_section_table_interpolator_top
    import xsti_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [S_W-1:0] i_energy_squared,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [Y_W-1:0] o_cross_section,
    output logic [1:0]     o_region
);

    // Pipeline advance: every stage moves unless a result is held at the output.
    logic en;

    logic           r_out_valid;
    logic [Y_W-1:0] r_out_y;
    t_region        r_out_region;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = r_out_valid && i_stall;

    // Square root stages.
    logic           sq_valid;
    logic [E_W-1:0] sq_root;

    xsti_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_valid),
        .i_radicand (i_energy_squared),
        .o_valid    (sq_valid),
        .o_root     (sq_root)
    );

    // Row search: index of the first row above the root, NUM_ROWS when none is.
    logic             r_s6_vld;
    logic [E_W-1:0]   r_s6_root;
    logic [IDX_W-1:0] r_s6_idx;
    logic [IDX_W-1:0] n_s6_idx;

    always_comb begin
        n_s6_idx = IDX_W'(NUM_ROWS);
        for (int i = NUM_ROWS - 1; i >= 0; i--) begin
            if (sq_root < ROM_E[i]) begin
                n_s6_idx = IDX_W'(i);
            end
        end
    end

    // Segment operands. Outside the table, and for a zero-width segment, the
    // answer is known here and rides past the divider as a bypass value.
    logic             r_s7_vld;
    logic [Y_W-1:0]   r_s7_ya;
    logic [Y_W-1:0]   r_s7_yb;
    logic [DEN_W-1:0] r_s7_t;
    logic [DEN_W-1:0] r_s7_u;
    logic [DEN_W-1:0] r_s7_den;
    t_side            r_s7_side;
    t_side            n_s7_side;
    logic [ROW_W-1:0] row_lo;
    logic [ROW_W-1:0] row_hi;
    logic [E_W-1:0]   ea;
    logic [E_W-1:0]   eb;
    logic [E_W-1:0]   den_full;

    always_comb begin
        if (r_s6_idx == IDX_W'(NUM_ROWS)) begin
            row_hi = ROW_W'(NUM_ROWS - 1);
        end else begin
            row_hi = r_s6_idx[ROW_W-1:0];
        end
        if (r_s6_idx == '0) begin
            row_lo = '0;
        end else begin
            row_lo = ROW_W'(r_s6_idx - IDX_W'(1));
        end
        ea       = ROM_E[row_lo];
        eb       = ROM_E[row_hi];
        den_full = eb - ea;

        if (r_s6_idx == '0) begin
            n_s7_side.region   = REGION_BELOW;
            n_s7_side.bypass   = 1'b1;
            n_s7_side.y_bypass = '0;
        end else if (r_s6_idx == IDX_W'(NUM_ROWS)) begin
            n_s7_side.region   = REGION_ABOVE;
            n_s7_side.bypass   = 1'b1;
            n_s7_side.y_bypass = ROM_Y[NUM_ROWS-1];
        end else begin
            n_s7_side.region   = REGION_INTERP;
            n_s7_side.bypass   = (den_full == '0);
            n_s7_side.y_bypass = ROM_Y[row_lo];
        end
    end

    // Products of the two weights: ya*(eb-R) and yb*(R-ea).
    logic              r_s8_vld;
    logic [PROD_W-1:0] r_s8_p0;
    logic [PROD_W-1:0] r_s8_p1;
    logic [DEN_W-1:0]  r_s8_den;
    t_side             r_s8_side;

    // Dividend 2*num + den and divisor 2*den for the rounded quotient.
    logic           r_s9_vld;
    logic [N_W-1:0] r_s9_num;
    logic [D_W-1:0] r_s9_dvs;
    t_side          r_s9_side;
    logic [N_W-1:0] prod_sum;

    assign prod_sum = N_W'(r_s8_p0) + N_W'(r_s8_p1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld <= 1'b0;
            r_s7_vld <= 1'b0;
            r_s8_vld <= 1'b0;
            r_s9_vld <= 1'b0;
        end else if (en) begin
            r_s6_vld <= sq_valid;
            r_s7_vld <= r_s6_vld;
            r_s8_vld <= r_s7_vld;
            r_s9_vld <= r_s8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s6_root <= sq_root;
            r_s6_idx  <= n_s6_idx;

            r_s7_ya   <= ROM_Y[row_lo];
            r_s7_yb   <= ROM_Y[row_hi];
            r_s7_t    <= DEN_W'(r_s6_root - ea);
            r_s7_u    <= DEN_W'(eb - r_s6_root);
            r_s7_den  <= DEN_W'(den_full);
            r_s7_side <= n_s7_side;

            r_s8_p0   <= PROD_W'(r_s7_ya) * PROD_W'(r_s7_u);
            r_s8_p1   <= PROD_W'(r_s7_yb) * PROD_W'(r_s7_t);
            r_s8_den  <= r_s7_den;
            r_s8_side <= r_s7_side;

            r_s9_num  <= {prod_sum[N_W-2:0], 1'b0} + N_W'(r_s8_den);
            r_s9_dvs  <= {r_s8_den, 1'b0};
            r_s9_side <= r_s8_side;
        end
    end

    // Rounded division.
    logic           dv_valid;
    logic [Y_W-1:0] dv_quotient;
    t_side          dv_side;

    xsti_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_s9_vld),
        .i_dividend (r_s9_num),
        .i_divisor  (r_s9_dvs),
        .i_side     (r_s9_side),
        .o_valid    (dv_valid),
        .o_quotient (dv_quotient),
        .o_side     (dv_side)
    );

    // Output register: picks the bypass value where the segment was not used.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_region <= dv_side.region;
            if (dv_side.bypass) begin
                r_out_y <= dv_side.y_bypass;
            end else begin
                r_out_y <= dv_quotient;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_cross_section = r_out_y;
    assign o_region        = r_out_region;

endmodule

### verif/tb_cross_section_table_interpolator_top.sv
// Self-checking testbench for cross_section_table_interpolator_top: table edges, row hits,
// then random lookups under changing back-pressure, checked against an in-bench predictor.
// Depends on xsti_pkg and the block's RTL only.
module tb_cross_section_table_interpolator_top
    import xsti_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // One result of a lookup, as the block should return it.
    typedef struct {
        logic [Y_W-1:0] xs;
        t_region        region;
    } t_xs_result;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_stall;
    logic [S_W-1:0] i_energy_squared;
    logic           o_valid;
    logic           i_stall;
    logic [Y_W-1:0] o_cross_section;
    logic [1:0]     o_region;

    cross_section_table_interpolator_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_energy_squared (i_energy_squared),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_cross_section  (o_cross_section),
        .o_region         (o_region)
    );

    // The table is rebuilt here from the physical numbers: energies as offsets in MeV
    // above the proton mass, cross sections in units of 1e-4 mb. This keeps the bench
    // independent of the constants coded into the package.
    localparam longint unsigned PROTON_MASS_E5 = 93827;
    localparam int unsigned ROW_OFFSET_MEV [NUM_ROWS] = '{
        185, 205, 223, 242, 260, 279, 290, 298, 315, 318, 337, 340, 357, 365,
        377, 390, 397, 415, 418, 438, 440, 459, 465, 481, 490, 502, 515, 524
    };
    localparam int unsigned ROW_XS_E4 [NUM_ROWS] = '{
        0,    1189, 1682, 2024, 3234, 3871, 4870, 5042, 5269, 5326, 5423, 4778, 4808, 4066,
        4110, 3341, 3119, 2444, 2496, 2109, 2245, 1742, 2005, 1888, 1783, 1764, 1769, 1671
    };

    logic [E_W-1:0] row_energy [NUM_ROWS];
    logic [Y_W-1:0] row_xs     [NUM_ROWS];

    // Results still owed by the block, oldest first.
    t_xs_result xs_expected [$];

    int errors;
    int lookups_sent;
    int results_checked;
    int region_count [3];

    // Idle control shared by the sender and the receiver. While quiet is set neither
    // side idles, which gives back-to-back stretches inside every random-lookup phase.
    int send_idle_pct;
    int recv_idle_pct;
    bit quiet;

    // Free-running clock, 10 ns period.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog. Its limit lies far beyond the length of any legal run, so hitting it
    // means the block hung or dropped results.
    initial begin
        #2ms;
        $display("Timeout with %0d results outstanding", xs_expected.size());
        $display("tb_cross_section_table_interpolator_top failed");
        $finish;
    end

    // Floor square root of s * 2^8, which is sqrt(s) in Q4.16. Built bit by bit from
    // the top; the square of a 20-bit trial always fits in 40 bits.
    function automatic logic [E_W-1:0] root_q4_16(input logic [S_W-1:0] s);
        logic [RAD_W-1:0] radicand;
        logic [E_W-1:0]   root;
        logic [E_W-1:0]   trial;
        radicand = {s, 8'h00};
        root     = '0;
        for (int b = E_W - 1; b >= 0; b--) begin
            trial = root | (E_W'(1) << b);
            if (RAD_W'(trial) * RAD_W'(trial) <= radicand) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Expected cross section and region for one squared energy.
    function automatic t_xs_result predict_xs(input logic [S_W-1:0] s);
        logic [E_W-1:0]  root;
        t_xs_result      res;
        bit              found;
        longint unsigned ea;
        longint unsigned eb;
        longint unsigned num;
        longint unsigned den;
        root  = root_q4_16(s);
        found = 1'b0;
        if (root < row_energy[0]) begin
            res.xs     = '0;
            res.region = REGION_BELOW;
        end else begin
            res.xs     = row_xs[NUM_ROWS-1];
            res.region = REGION_ABOVE;
            for (int i = 1; i < NUM_ROWS; i++) begin
                if (!found && root < row_energy[i]) begin
                    found      = 1'b1;
                    res.region = REGION_INTERP;
                    ea         = row_energy[i-1];
                    eb         = row_energy[i];
                    den        = eb - ea;
                    if (den == 0) begin
                        res.xs = row_xs[i-1];
                    end else begin
                        // Weighted sum of the two neighbors, rounded half up.
                        num    = row_xs[i-1] * (eb - root) + row_xs[i] * (root - ea);
                        res.xs = Y_W'((2 * num + den) / (2 * den));
                    end
                end
            end
        end
        return res;
    endfunction

    // Smallest s whose root equals r, and largest s whose root lies below r.
    function automatic logic [S_W-1:0] energy_sq_at(input logic [E_W-1:0] r);
        longint unsigned sq;
        sq = longint'(r) * longint'(r);
        return S_W'((sq + 255) / 256);
    endfunction

    function automatic logic [S_W-1:0] energy_sq_under(input logic [E_W-1:0] r);
        longint unsigned sq;
        sq = longint'(r) * longint'(r);
        return S_W'((sq - 1) / 256);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("[%0t] MISMATCH %s: got %0d, expected %0d (result %0d)",
                 $realtime, what, got, want, results_checked);
    endtask

    // Present one lookup and hold it until the block takes it. Called and returning
    // at a falling edge. Valid is only lowered when the sender chooses to idle, so
    // back-to-back transactions never see a low and a high in the same time step.
    task automatic send_energy(input logic [S_W-1:0] s);
        while (!quiet && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_energy_squared <= s;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        xs_expected = {xs_expected, predict_xs(s)};
        lookups_sent++;
        @(negedge i_clk);
    endtask

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge i_clk) begin
        i_stall <= !quiet && ($urandom_range(99) < recv_idle_pct);
    end

    // Every result that leaves the block is matched against the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_xs_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (xs_expected.size() == 0) begin
                report_mismatch("result with nothing outstanding", o_cross_section, 0);
            end else begin
                want = xs_expected.pop_front();
                if (o_cross_section !== want.xs) begin
                    report_mismatch("cross_section", o_cross_section, want.xs);
                end
                if (o_region !== want.region) begin
                    report_mismatch("region", o_region, want.region);
                end
                if (want.region <= REGION_ABOVE) begin
                    region_count[want.region]++;
                end
            end
            results_checked++;
        end
    end

    // Zero, one, all ones, the top bit alone, the two sides of the first and last row,
    // and one step beyond the top of the table.
    task automatic test_table_corners();
        send_energy('0);
        send_energy(32'h0000_0001);
        send_energy('1);
        send_energy(32'h8000_0000);
        send_energy(energy_sq_under(row_energy[0]));
        send_energy(energy_sq_at(row_energy[0]));
        send_energy(energy_sq_under(row_energy[NUM_ROWS-1]));
        send_energy(energy_sq_at(row_energy[NUM_ROWS-1]));
        send_energy(energy_sq_at(row_energy[NUM_ROWS-1] + E_W'(1)));
    endtask

    // Lookups that land exactly on a row, and just below it, for a spread of rows
    // including the peak and the falling edge after it.
    task automatic test_row_hits();
        int rows [7] = '{1, 6, 10, 11, 13, 20, 26};
        foreach (rows[k]) begin
            send_energy(energy_sq_at(row_energy[rows[k]]));
            send_energy(energy_sq_under(row_energy[rows[k]]));
        end
    endtask

    // Random lookups. Most roots fall in or just around the table so that every
    // segment is exercised; some land on row boundaries, and the rest are full-width
    // random words that toggle every input bit.
    task automatic test_random_lookups(input int count, input int send_pct, input int recv_pct);
        logic [E_W-1:0] root;
        int             pick;
        int             row;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < count; n++) begin
            quiet = ((n / 40) % 4) == 3;
            pick  = $urandom_range(99);
            if (pick < 70) begin
                root = E_W'($urandom_range(row_energy[NUM_ROWS-1] + 600, row_energy[0] - 600));
                send_energy(energy_sq_at(root) + $urandom_range(2 * root / 256));
            end else if (pick < 85) begin
                row = $urandom_range(NUM_ROWS - 1);
                if ($urandom_range(1)) begin
                    send_energy(energy_sq_at(row_energy[row]));
                end else begin
                    send_energy(energy_sq_under(row_energy[row]));
                end
            end else begin
                send_energy($urandom);
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_stall          = 1'b0;
        i_energy_squared = '0;
        errors           = 0;
        lookups_sent     = 0;
        results_checked  = 0;
        region_count     = '{0, 0, 0};
        quiet            = 1'b0;
        send_idle_pct    = 35;
        recv_idle_pct    = 52;

        // Q4.16 energies and Q0.16 cross sections, each rounded half up.
        for (int i = 0; i < NUM_ROWS; i++) begin
            row_energy[i] = E_W'(((PROTON_MASS_E5 + longint'(ROW_OFFSET_MEV[i]) * 100) * 65536
                                  + 50000) / 100000);
            row_xs[i]     = Y_W'((longint'(ROW_XS_E4[i]) * 65536 + 5000) / 10000);
        end

        // Synchronous reset, released on a falling edge.
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed checks run under the first back-pressure setting.
        test_table_corners();
        test_row_hits();

        // Sender idles more lightly than the receiver, then the reverse, then no
        // idling at all so the pipeline runs at one transaction per cycle.
        test_random_lookups(270, 35, 52);
        test_random_lookups(270, 52, 35);
        test_random_lookups(270, 0, 0);
        i_valid <= 1'b0;

        // Drain, then give the 14-stage pipeline time to show any stray result.
        while (xs_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);

        $display("Sent %0d lookups and checked %0d results under three back-pressure mixes.",
                 lookups_sent, results_checked);
        $display("Regions seen: %0d below the table, %0d between rows, %0d at or past the top.",
                 region_count[REGION_BELOW], region_count[REGION_INTERP],
                 region_count[REGION_ABOVE]);
        if (errors == 0) begin
            $display("tb_cross_section_table_interpolator_top passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("tb_cross_section_table_interpolator_top failed");
        end
        $finish;
    end

endmodule
